### sv/cprf_pkg.sv
// Package for the collision pair rule filter: payload structs, op codes and
// internal command types. No dependencies.
package cprf_pkg;

	localparam int BODY_BITS    = 10;
	localparam int PAIR_ENTRIES = 32;
	localparam int GROUP_COUNT  = 16;
	localparam int BODY_DEPTH   = 1 << BODY_BITS;

	// Op codes with special meaning.
	localparam logic [4:0] OP_QUERY         = 5'd0;
	localparam logic [4:0] OP_FIRST_EXC     = 5'd9;
	localparam logic [4:0] OP_LAST_TABLE    = 5'd16;
	localparam logic [4:0] OP_CLEAR         = 5'd17;
	localparam logic [4:0] OP_PAIR_ADD_RULE = 5'd3;
	localparam logic [4:0] OP_PAIR_ADD_EXC  = 5'd11;

	// Operation kind inside a rule or exception bank.
	localparam logic [2:0] K_BODY_ADD  = 3'd0;
	localparam logic [2:0] K_BODY_DEL  = 3'd1;
	localparam logic [2:0] K_PAIR_ADD  = 3'd2;
	localparam logic [2:0] K_PAIR_DEL  = 3'd3;
	localparam logic [2:0] K_GROUP_ADD = 3'd4;
	localparam logic [2:0] K_GROUP_DEL = 3'd5;
	localparam logic [2:0] K_GPAIR_ADD = 3'd6;
	localparam logic [2:0] K_GPAIR_DEL = 3'd7;

	// Who decided a query.
	localparam logic [2:0] DEC_DEFAULT  = 3'd0;
	localparam logic [2:0] DEC_BODY     = 3'd1;
	localparam logic [2:0] DEC_GROUP    = 3'd2;
	localparam logic [2:0] DEC_PAIR     = 3'd3;
	localparam logic [2:0] DEC_GPAIR    = 3'd4;
	localparam logic [2:0] DEC_NONQUERY = 3'd5;

	// Per-body mark codes.
	localparam logic [1:0] MARK_NONE   = 2'd0;
	localparam logic [1:0] MARK_ALLOW  = 2'd1;
	localparam logic [1:0] MARK_REJECT = 2'd2;

	typedef struct packed {
		logic [4:0]             op;
		logic [BODY_BITS-1:0]   body_a;
		logic [BODY_BITS-1:0]   body_b;
		logic [GROUP_COUNT-1:0] groups_a;
		logic [GROUP_COUNT-1:0] groups_b;
		logic [3:0]             group_a;
		logic [3:0]             group_b;
	} cmd_t;

	typedef struct packed {
		logic       allowed;
		logic [2:0] decided_by;
		logic       status;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PC_NOP,
		PC_PURGE,
		PC_INSERT,
		PC_REMOVE,
		PC_CLEAR
	} pair_op_t;

	// Command broadcast to every pair cell.
	typedef struct packed {
		pair_op_t             kind;
		logic [BODY_BITS-1:0] lo;
		logic [BODY_BITS-1:0] hi;
		logic                 reject;
	} pair_cmd_t;

	// Status handed from one pair cell to the next.
	typedef struct packed {
		logic free_seen;
		logic hit;
		logic rej_hit;
	} pair_chain_t;

endpackage

### sv/collision_pair_rule_filter_core.sv
// Top level of the collision pair rule filter: body mark memory, group tables,
// control sequencer and result register. Depends on cprf_pkg, cprf_pair_table.
//
// Each command beat passes through accept, body mark memory read, execute and
// result steps before the done strobe; the body mark memory has a single
// write port, so a pair insert clears the marks of both bodies one per cycle.
// A clear command and reset each sweep the 1024-entry mark memory one entry a
// cycle, so busy stays high through the sweep after a clear, and after reset.
// The result beat is shown for one cycle only and cannot be held off; the
// default_allowed register may be written at any time the block is idle.
module collision_pair_rule_filter_core import cprf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result,
	input  logic    cfg_we,
	input  logic    cfg_wdata
);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic   dflt_q;
	logic   done_q;
	logic   clr_item_q;
	result_t res_q, res_d;
	logic [BODY_BITS-1:0] clr_cnt_q;

	// Body mark memory.
	logic [1:0]           marks [BODY_DEPTH];
	logic [1:0]           mark_a_q, mark_b_q;
	logic                 mem_we;
	logic [BODY_BITS-1:0] mem_waddr;
	logic [1:0]           mem_wdata;

	// Group tables.
	logic [GROUP_COUNT-1:0] ag_q, rg_q, ag_d, rg_d;
	logic [GROUP_COUNT-1:0] apm_q [GROUP_COUNT];
	logic [GROUP_COUNT-1:0] rpm_q [GROUP_COUNT];
	logic [GROUP_COUNT-1:0] apm_d [GROUP_COUNT];
	logic [GROUP_COUNT-1:0] rpm_d [GROUP_COUNT];

	// Decode.
	logic                 tbl_op, reject;
	logic [2:0]           kind;
	logic [4:0]           op_m1;
	logic [BODY_BITS-1:0] lo, hi;
	logic                 same_body, same_group;
	logic [1:0]           own_mark;
	pair_cmd_t            pcmd;
	logic                 p_hit, p_rej_hit, p_full;

	// Group pair scan.
	logic                 gp_found, gp_allow;
	logic [GROUP_COUNT-1:0] row_hit;

	// Group add helper values.
	logic                 grp_add;
	logic [3:0]           grp_idx;
	logic [GROUP_COUNT-1:0] gbit, g1bit, g2bit;

	assign op_m1      = cmd_q.op - 5'd1;
	assign kind       = op_m1[2:0];
	assign tbl_op     = cmd_q.op != OP_QUERY && cmd_q.op <= OP_LAST_TABLE;
	assign reject     = cmd_q.op >= OP_FIRST_EXC;
	assign lo         = (cmd_q.body_a < cmd_q.body_b) ? cmd_q.body_a : cmd_q.body_b;
	assign hi         = (cmd_q.body_a < cmd_q.body_b) ? cmd_q.body_b : cmd_q.body_a;
	assign same_body  = cmd_q.body_a == cmd_q.body_b;
	assign same_group = cmd_q.group_a == cmd_q.group_b;
	assign own_mark   = reject ? MARK_REJECT : MARK_ALLOW;
	assign g1bit      = GROUP_COUNT'(1) << cmd_q.group_a;
	assign g2bit      = GROUP_COUNT'(1) << cmd_q.group_b;
	assign gbit       = GROUP_COUNT'(1) << grp_idx;
	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign result     = res_q;

	// Pair table command, issued only in the execute cycle.
	always_comb begin
		pcmd.kind   = PC_NOP;
		pcmd.lo     = lo;
		pcmd.hi     = hi;
		pcmd.reject = reject;
		if (state_q == ST_EXEC) begin
			if (cmd_q.op == OP_CLEAR) begin
				pcmd.kind = PC_CLEAR;
			end else if (tbl_op) begin
				case (kind)
					K_BODY_ADD: begin
						pcmd.kind = PC_PURGE;
						pcmd.lo   = cmd_q.body_a;
					end
					K_PAIR_ADD: begin
						pcmd.kind = PC_INSERT;
						if (same_body) begin
							pcmd.kind = PC_PURGE;
							pcmd.lo   = cmd_q.body_a;
						end
					end
					K_PAIR_DEL: pcmd.kind = PC_REMOVE;
					default:    pcmd.kind = PC_NOP;
				endcase
			end
		end
	end

	cprf_pair_table u_pairs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (pcmd),
		.hit     (p_hit),
		.rej_hit (p_rej_hit),
		.full    (p_full)
	);

	// Group pair scan: lowest first group, then lowest second group wins.
	always_comb begin
		gp_found = 1'b0;
		gp_allow = 1'b0;
		for (int g1 = GROUP_COUNT - 1; g1 >= 0; g1--) begin
			row_hit[g1] = cmd_q.groups_a[g1] &&
				(((apm_q[g1] | rpm_q[g1]) & cmd_q.groups_b) != '0);
		end
		for (int g1 = GROUP_COUNT - 1; g1 >= 0; g1--) begin
			if (row_hit[g1]) begin
				gp_found = 1'b1;
				for (int g2 = GROUP_COUNT - 1; g2 >= 0; g2--) begin
					if (cmd_q.groups_b[g2] && (apm_q[g1][g2] || rpm_q[g1][g2])) begin
						gp_allow = apm_q[g1][g2];
					end
				end
			end
		end
	end

	// Result of the current command.
	always_comb begin
		res_d.allowed    = 1'b0;
		res_d.decided_by = DEC_NONQUERY;
		res_d.status     = 1'b0;
		if (cmd_q.op == OP_QUERY) begin
			if (mark_a_q == MARK_ALLOW || mark_b_q == MARK_ALLOW) begin
				res_d.allowed    = 1'b1;
				res_d.decided_by = DEC_BODY;
			end else if (mark_a_q == MARK_REJECT || mark_b_q == MARK_REJECT) begin
				res_d.decided_by = DEC_BODY;
			end else if ((ag_q & (cmd_q.groups_a | cmd_q.groups_b)) != '0) begin
				res_d.allowed    = 1'b1;
				res_d.decided_by = DEC_GROUP;
			end else if ((rg_q & (cmd_q.groups_a | cmd_q.groups_b)) != '0) begin
				res_d.decided_by = DEC_GROUP;
			end else if (p_hit) begin
				res_d.allowed    = ~p_rej_hit;
				res_d.decided_by = DEC_PAIR;
			end else if (gp_found) begin
				res_d.allowed    = gp_allow;
				res_d.decided_by = DEC_GPAIR;
			end else begin
				res_d.allowed    = dflt_q;
				res_d.decided_by = DEC_DEFAULT;
			end
		end else if (tbl_op && kind == K_PAIR_ADD && !same_body) begin
			res_d.status = ~p_hit & p_full;
		end
	end

	// Group table updates.
	always_comb begin
		ag_d    = ag_q;
		rg_d    = rg_q;
		apm_d   = apm_q;
		rpm_d   = rpm_q;
		grp_add = 1'b0;
		grp_idx = cmd_q.group_a;
		if (state_q == ST_EXEC) begin
			if (cmd_q.op == OP_CLEAR) begin
				ag_d = '0;
				rg_d = '0;
				for (int i = 0; i < GROUP_COUNT; i++) begin
					apm_d[i] = '0;
					rpm_d[i] = '0;
				end
			end else if (tbl_op) begin
				case (kind)
					K_GROUP_ADD: grp_add = 1'b1;
					K_GROUP_DEL: begin
						if (reject) rg_d = rg_q & ~g1bit;
						else ag_d = ag_q & ~g1bit;
					end
					K_GPAIR_ADD: begin
						if (same_group) begin
							grp_add = 1'b1;
						end else begin
							if (reject) begin
								rpm_d[cmd_q.group_a] = rpm_q[cmd_q.group_a] | g2bit;
								rpm_d[cmd_q.group_b] = rpm_q[cmd_q.group_b] | g1bit;
								apm_d[cmd_q.group_a] = apm_q[cmd_q.group_a] & ~g2bit;
								apm_d[cmd_q.group_b] = apm_q[cmd_q.group_b] & ~g1bit;
							end else begin
								apm_d[cmd_q.group_a] = apm_q[cmd_q.group_a] | g2bit;
								apm_d[cmd_q.group_b] = apm_q[cmd_q.group_b] | g1bit;
								rpm_d[cmd_q.group_a] = rpm_q[cmd_q.group_a] & ~g2bit;
								rpm_d[cmd_q.group_b] = rpm_q[cmd_q.group_b] & ~g1bit;
							end
							ag_d = ag_q & ~(g1bit | g2bit);
							rg_d = rg_q & ~(g1bit | g2bit);
						end
					end
					K_GPAIR_DEL: begin
						if (!same_group) begin
							if (reject) begin
								rpm_d[cmd_q.group_a] = rpm_q[cmd_q.group_a] & ~g2bit;
								rpm_d[cmd_q.group_b] = rpm_q[cmd_q.group_b] & ~g1bit;
							end else begin
								apm_d[cmd_q.group_a] = apm_q[cmd_q.group_a] & ~g2bit;
								apm_d[cmd_q.group_b] = apm_q[cmd_q.group_b] & ~g1bit;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		// A group rule purges every group pair that names the group.
		if (grp_add) begin
			if (reject) begin
				rg_d = rg_q | gbit;
				ag_d = ag_q & ~gbit;
			end else begin
				ag_d = ag_q | gbit;
				rg_d = rg_q & ~gbit;
			end
			for (int i = 0; i < GROUP_COUNT; i++) begin
				apm_d[i] = apm_q[i] & ~gbit;
				rpm_d[i] = rpm_q[i] & ~gbit;
			end
			apm_d[grp_idx] = '0;
			rpm_d[grp_idx] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ag_q <= '0;
			rg_q <= '0;
			for (int i = 0; i < GROUP_COUNT; i++) begin
				apm_q[i] <= '0;
				rpm_q[i] <= '0;
			end
		end else begin
			ag_q  <= ag_d;
			rg_q  <= rg_d;
			apm_q <= apm_d;
			rpm_q <= rpm_d;
		end
	end

	// Mark memory write port: clearing sweep, then first body, then second body.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cmd_q.body_a;
		mem_wdata = MARK_NONE;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			ST_EXEC: begin
				if (tbl_op) begin
					case (kind)
						K_BODY_ADD: begin
							mem_we    = 1'b1;
							mem_wdata = own_mark;
						end
						K_BODY_DEL: mem_we = mark_a_q == own_mark;
						K_PAIR_ADD: begin
							mem_we    = 1'b1;
							mem_wdata = same_body ? own_mark : MARK_NONE;
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			ST_DONE: begin
				mem_we    = tbl_op && kind == K_PAIR_ADD && !same_body;
				mem_waddr = cmd_q.body_b;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) marks[mem_waddr] <= mem_wdata;
		mark_a_q <= marks[cmd_q.body_a];
		mark_b_q <= marks[cmd_q.body_b];
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_cnt_q == '1) state_d = clr_item_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = (cmd_q.op == OP_CLEAR) ? ST_CLR : ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_cnt_q  <= '0;
			clr_item_q <= 1'b0;
			done_q     <= 1'b0;
			dflt_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_d == ST_DONE;
			if (cfg_we) dflt_q <= cfg_wdata;
			if (state_q == ST_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == ST_EXEC) clr_item_q <= cmd_q.op == OP_CLEAR;
		end
	end

	// Command beat and result registers.
	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= cmd;
		if (state_q == ST_EXEC) res_q <= res_d;
	end

	// Non-query commands report no decision.
	a_nonquery: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q.op != OP_QUERY) |-> (result.decided_by == DEC_NONQUERY &&
		!result.allowed))
		else $error("non-query result carries a decision");

	// An accepted beat moves straight to the memory read.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == ST_READ)
		else $error("accepted beat did not start a read");

	// One result strobe per command.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// Only a pair insert can report a full table.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (cmd_q.op == OP_PAIR_ADD_RULE ||
		cmd_q.op == OP_PAIR_ADD_EXC))
		else $error("full flag on a command other than a pair insert");

	// The strobe comes only while the sequencer shows its result.
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy && $past(state_q == ST_EXEC || state_q == ST_CLR)))
		else $error("result strobe outside the result cycle");

endmodule

### sv/cprf_cell.sv
// One pair cell: holds one ordered body pair entry and passes search status
// on to its neighbor. Depends on cprf_pkg.
module cprf_cell import cprf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pair_cmd_t   cmd,
	input  logic        ins_new,
	input  pair_chain_t chain_in,
	output pair_chain_t chain_out
);

	logic                 valid_q;
	logic                 rej_q;
	logic [BODY_BITS-1:0] lo_q;
	logic [BODY_BITS-1:0] hi_q;
	logic                 match_key;
	logic                 touch;
	logic                 take;

	// Compare against the broadcast key.
	assign match_key = valid_q && lo_q == cmd.lo && hi_q == cmd.hi;
	assign touch     = valid_q && (lo_q == cmd.lo || hi_q == cmd.lo);
	assign take      = ins_new && !valid_q && !chain_in.free_seen;

	// Hand the running status to the next cell.
	assign chain_out.free_seen = chain_in.free_seen | ~valid_q;
	assign chain_out.hit       = chain_in.hit | match_key;
	assign chain_out.rej_hit   = chain_in.rej_hit | (match_key & rej_q);

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.kind)
				PC_PURGE: begin
					if (touch) valid_q <= 1'b0;
				end
				PC_INSERT: begin
					if (!match_key && take) valid_q <= 1'b1;
				end
				PC_REMOVE: begin
					if (match_key && rej_q == cmd.reject) valid_q <= 1'b0;
				end
				PC_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (cmd.kind == PC_INSERT) begin
			if (match_key) begin
				rej_q <= cmd.reject;
			end else if (take) begin
				rej_q <= cmd.reject;
				lo_q  <= cmd.lo;
				hi_q  <= cmd.hi;
			end
		end
	end

endmodule

### sv/cprf_pair_table.sv
// Row of pair cells forming the body pair table, with its search summary.
// Depends on cprf_pkg and cprf_cell.
module cprf_pair_table import cprf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pair_cmd_t cmd,
	output logic      hit,
	output logic      rej_hit,
	output logic      full
);

	pair_chain_t chain [PAIR_ENTRIES+1];
	logic        ins_new;

	assign chain[0] = '0;
	// A new entry goes in only when no cell already holds the key.
	assign ins_new = ~chain[PAIR_ENTRIES].hit;

	for (genvar i = 0; i < PAIR_ENTRIES; i++) begin : g_cell
		cprf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.ins_new   (ins_new),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign hit     = chain[PAIR_ENTRIES].hit;
	assign rej_hit = chain[PAIR_ENTRIES].rej_hit;
	assign full    = ~chain[PAIR_ENTRIES].free_seen;

endmodule
